[rtl/bdq_pkg.sv]
// ----------------------------------------------------------------------------
// bdq_pkg
// Types and constants shared by the bounded deque with sort.
// ----------------------------------------------------------------------------
package bdq_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;
	localparam int PTR_W      = $clog2(DEPTH);
	localparam int CNT_W      = $clog2(DEPTH + 1);

	localparam logic [3:0] MODE_PUSH_FRONT = 4'd0;
	localparam logic [3:0] MODE_PUSH_BACK  = 4'd1;
	localparam logic [3:0] MODE_POP_FRONT  = 4'd2;
	localparam logic [3:0] MODE_POP_BACK   = 4'd3;
	localparam logic [3:0] MODE_READ_INDEX = 4'd4;
	localparam logic [3:0] MODE_READ_BACK  = 4'd5;
	localparam logic [3:0] MODE_SORT       = 4'd6;
	localparam logic [3:0] MODE_REVERSE    = 4'd7;
	localparam logic [3:0] MODE_CLEAR      = 4'd8;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_RANGE = 2'd2;
	localparam logic [1:0] STAT_FULL  = 2'd3;

	typedef struct packed {
		logic [3:0]                   mode;
		logic signed [DATA_WIDTH-1:0] value;
		logic [PTR_W-1:0]             index;
	} req_t;

	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] data;
		logic [1:0]                   status;
		logic [CNT_W-1:0]             count;
	} rsp_t;

endpackage

[rtl/bounded_deque_with_sort_top.sv]
// ----------------------------------------------------------------------------
// bounded_deque_with_sort_top
// Bounded double-ended queue of signed words held in one synchronous RAM.
//
//   channel | dir | handshake             | payload
//   req     | in  | req_valid / req_stall | req (mode, value, index)
//   rsp     | out | rsp_valid / rsp_stall | rsp (data, status, count)
//
// Push, reverse, clear, errors, unused modes and sorts of n < 2 elements load
// the result register as they are taken. Pop and reads pass the RAM read
// register and the read state into it. Sort of n > 1 elements: bubble passes
// over the RAM, at most one read and one write per cycle. A request is taken
// only when the block is idle and the result register is free or being
// drained. Reset clears pointers, count and flag; RAM is not reset.
// ----------------------------------------------------------------------------
module bounded_deque_with_sort_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  bdq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output bdq_pkg::rsp_t rsp
);
	import bdq_pkg::*;

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_READ  = 6'b000010,
		ST_START = 6'b000100,
		ST_LOAD  = 6'b001000,
		ST_STEP  = 6'b010000,
		ST_TAIL  = 6'b100000
	} state_t;

	logic signed [DATA_WIDTH-1:0] mem [DEPTH];
	logic signed [DATA_WIDTH-1:0] rdata_q;

	state_t           state_q;
	logic [PTR_W-1:0] fp_q;
	logic [CNT_W-1:0] cnt_q;
	logic             rev_q;
	logic             rsp_valid_q;
	rsp_t             rsp_q;
	logic [PTR_W-1:0] k_q;
	logic [PTR_W-1:0] lim_q;
	logic signed [DATA_WIDTH-1:0] cur_q;

	logic             accept;
	logic             we;
	logic [PTR_W-1:0] waddr;
	logic signed [DATA_WIDTH-1:0] wdata;
	logic             re;
	logic [PTR_W-1:0] raddr;
	logic [PTR_W-1:0] cnt_lo;
	logic [PTR_W-1:0] last_slot;
	logic [PTR_W-1:0] idx_slot;
	logic             low_end;
	logic             full;
	logic             empty;
	logic             in_range;
	logic             cur_gt;
	logic             defer;
	rsp_t             nxt_rsp;

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE) || (rsp_valid_q && rsp_stall);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	assign cnt_lo    = cnt_q[PTR_W-1:0];
	assign full      = (cnt_q == CNT_W'(DEPTH));
	assign empty     = (cnt_q == '0);
	assign in_range  = ({1'b0, req.index} < cnt_q);
	assign last_slot = fp_q + cnt_lo - PTR_W'(1);
	assign idx_slot  = rev_q ? (last_slot - req.index) : (fp_q + req.index);
	assign cur_gt    = cur_q > rdata_q;

	always_comb begin
		low_end = 1'b0;
		case (req.mode)
			MODE_PUSH_FRONT, MODE_POP_FRONT: low_end = !rev_q;
			MODE_PUSH_BACK, MODE_POP_BACK:   low_end = rev_q;
			default:                         low_end = 1'b0;
		endcase
	end

	always_comb begin
		nxt_rsp.data   = '0;
		nxt_rsp.status = STAT_OK;
		nxt_rsp.count  = cnt_q;
		defer          = 1'b0;
		case (req.mode)
			MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
				if (full) begin
					nxt_rsp.status = STAT_FULL;
				end else begin
					nxt_rsp.count = cnt_q + CNT_W'(1);
				end
			end
			MODE_POP_FRONT, MODE_POP_BACK: begin
				if (empty) begin
					nxt_rsp.status = STAT_EMPTY;
				end else begin
					nxt_rsp.count = cnt_q - CNT_W'(1);
					defer         = 1'b1;
				end
			end
			MODE_READ_INDEX: begin
				if (in_range) begin
					defer = 1'b1;
				end else begin
					nxt_rsp.status = STAT_RANGE;
				end
			end
			MODE_READ_BACK: begin
				if (empty) begin
					nxt_rsp.status = STAT_EMPTY;
				end else begin
					defer = 1'b1;
				end
			end
			MODE_SORT: begin
				defer = (cnt_q > CNT_W'(1));
			end
			MODE_CLEAR: begin
				nxt_rsp.count = '0;
			end
			default: ;
		endcase
	end

	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = req.value;
		re    = 1'b0;
		raddr = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (req.mode)
						MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
							we    = !full;
							waddr = low_end ? (fp_q - PTR_W'(1)) : (fp_q + cnt_lo);
						end
						MODE_POP_FRONT, MODE_POP_BACK: begin
							re    = !empty;
							raddr = low_end ? fp_q : last_slot;
						end
						MODE_READ_INDEX: begin
							re    = in_range;
							raddr = idx_slot;
						end
						MODE_READ_BACK: begin
							re    = !empty;
							raddr = rev_q ? fp_q : last_slot;
						end
						default: ;
					endcase
				end
			end
			ST_START: begin
				re    = 1'b1;
				raddr = fp_q;
			end
			ST_LOAD: begin
				re    = 1'b1;
				raddr = fp_q + k_q;
			end
			ST_STEP: begin
				we    = 1'b1;
				waddr = fp_q + k_q - PTR_W'(1);
				wdata = cur_gt ? rdata_q : cur_q;
				re    = (k_q != lim_q);
				raddr = fp_q + k_q + PTR_W'(1);
			end
			ST_TAIL: begin
				we    = 1'b1;
				waddr = fp_q + lim_q;
				wdata = cur_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fp_q        <= '0;
			cnt_q       <= '0;
			rev_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
			k_q         <= '0;
			lim_q       <= '0;
			cur_q       <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						rsp_q       <= nxt_rsp;
						rsp_valid_q <= !defer;
						case (req.mode)
							MODE_PUSH_FRONT, MODE_PUSH_BACK: begin
								if (!full) begin
									cnt_q <= cnt_q + CNT_W'(1);
									if (low_end) begin
										fp_q <= fp_q - PTR_W'(1);
									end
								end
							end
							MODE_POP_FRONT, MODE_POP_BACK: begin
								if (!empty) begin
									state_q <= ST_READ;
									cnt_q   <= cnt_q - CNT_W'(1);
									if (low_end) begin
										fp_q <= fp_q + PTR_W'(1);
									end
								end
							end
							MODE_READ_INDEX: begin
								if (in_range) begin
									state_q <= ST_READ;
								end
							end
							MODE_READ_BACK: begin
								if (!empty) begin
									state_q <= ST_READ;
								end
							end
							MODE_SORT: begin
								rev_q <= 1'b0;
								if (cnt_q > CNT_W'(1)) begin
									lim_q   <= cnt_lo - PTR_W'(1);
									state_q <= ST_START;
								end
							end
							MODE_REVERSE: begin
								rev_q <= !rev_q;
							end
							MODE_CLEAR: begin
								cnt_q <= '0;
								fp_q  <= '0;
								rev_q <= 1'b0;
							end
							default: ;
						endcase
					end else if (!rsp_stall) begin
						rsp_valid_q <= 1'b0;
					end
				end
				ST_READ: begin
					rsp_q.data  <= rdata_q;
					rsp_valid_q <= 1'b1;
					state_q     <= ST_IDLE;
				end
				ST_START: begin
					k_q     <= PTR_W'(1);
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					cur_q   <= rdata_q;
					state_q <= ST_STEP;
				end
				ST_STEP: begin
					if (!cur_gt) begin
						cur_q <= rdata_q;
					end
					if (k_q == lim_q) begin
						state_q <= ST_TAIL;
					end else begin
						k_q <= k_q + PTR_W'(1);
					end
				end
				ST_TAIL: begin
					if (lim_q == PTR_W'(1)) begin
						rsp_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end else begin
						lim_q   <= lim_q - PTR_W'(1);
						state_q <= ST_START;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
